// ----- src/drt_pkg.sv -----
// Package for the drive ramp and turn integrator block.
// Holds the item structs, the configuration struct, register indexes and constants.
// It has no dependencies; every other file uses it by scoped names.
package drt_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 12;

  localparam logic [CfgIdxWidth-1:0] CfgMoveAccel    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgMoveBrake    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgTurnAccel    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgTurnDeadZone = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgTurnLimit    = 3'd4;

  localparam logic [6:0]  MoveAccelReset    = 7'd2;
  localparam logic [6:0]  MoveBrakeReset    = 7'd5;
  localparam logic [6:0]  TurnAccelReset    = 7'd6;
  localparam logic [6:0]  TurnDeadZoneReset = 7'd3;
  localparam logic [11:0] TurnLimitReset    = 12'd1000;

  localparam logic signed [9:0]  DriveMax   = 10'sd127;
  localparam logic signed [16:0] PitchMax   = 17'sd850;
  localparam logic [9:0]         PitchRest  = 10'd550;
  // floor(m / 6) for m below 4096 is (m * 2731) >> 14.
  localparam logic [11:0]        Div6Recip  = 12'd2731;
  // floor(p * 3 / 10) for p up to 850 is (p * 19662) >> 16.
  localparam logic [14:0]        PitchScale = 15'd19662;

  typedef struct packed {
    logic              cmd;
    logic              link_up;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
    logic [3:0]        keys;
    logic signed [15:0] turn_delta;
    logic signed [15:0] pitch_delta;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] strafe_drive;
    logic signed [7:0] move_drive;
    logic signed [7:0] turn_drive;
    logic [9:0]        pitch_position;
    logic [7:0]        pitch_byte;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  move_accel;
    logic [6:0]  move_brake;
    logic [6:0]  turn_accel;
    logic [6:0]  turn_dead_zone;
    logic [11:0] turn_limit;
  } cfg_t;

endpackage

// ----- src/drive_ramp_turn_integrator_top.sv -----
// Top level of the drive ramp and turn integrator: state, configuration and result register.
// Depends on drt_pkg, drt_ramp and drt_turn.
// A result is shown in the cycle after its item is accepted.
// Throughput: one item per cycle; the state update is a single pass from the state registers.
// A waiting result does not block input while the consumer takes it in the same cycle.
// Reset clears the state and the result valid flag and loads the register defaults.
module drive_ramp_turn_integrator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  drt_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output drt_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drt_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [drt_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  drt_pkg::cfg_t      cfg_q;
  logic signed [7:0]  strafe_q, strafe_d;
  logic signed [7:0]  move_q, move_d;
  logic signed [7:0]  turn_q, turn_d;
  logic signed [12:0] integ_q, integ_d;
  logic [9:0]         pitch_q, pitch_d;
  logic signed [7:0]  strafe_step, move_step, turn_step;
  logic signed [12:0] integ_step;
  logic signed [16:0] pitch_sum;
  logic [9:0]         pitch_step;
  logic [24:0]        pitch_prod;
  logic               out_valid_q;
  drt_pkg::out_item_t out_q;
  logic               in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  drt_ramp u_ramp_x (
    .cur_i     (strafe_q),
    .stick_i   (in_data_i.stick_x),
    .key_neg_i (in_data_i.keys[0]),
    .key_pos_i (in_data_i.keys[1]),
    .accel_i   (cfg_q.move_accel),
    .brake_i   (cfg_q.move_brake),
    .next_o    (strafe_step)
  );

  drt_ramp u_ramp_y (
    .cur_i     (move_q),
    .stick_i   (in_data_i.stick_y),
    .key_neg_i (in_data_i.keys[2]),
    .key_pos_i (in_data_i.keys[3]),
    .accel_i   (cfg_q.move_accel),
    .brake_i   (cfg_q.move_brake),
    .next_o    (move_step)
  );

  drt_turn u_turn (
    .integ_i (integ_q),
    .turn_i  (turn_q),
    .delta_i (in_data_i.turn_delta),
    .cfg_i   (cfg_q),
    .integ_o (integ_step),
    .turn_o  (turn_step)
  );

  always_comb begin
    pitch_sum = $signed({7'd0, pitch_q}) + 17'(in_data_i.pitch_delta);
    if (pitch_sum < 17'sd0) begin
      pitch_step = '0;
    end else if (pitch_sum > drt_pkg::PitchMax) begin
      pitch_step = drt_pkg::PitchMax[9:0];
    end else begin
      pitch_step = pitch_sum[9:0];
    end

    strafe_d = strafe_q;
    move_d   = move_q;
    turn_d   = turn_q;
    integ_d  = integ_q;
    pitch_d  = pitch_q;
    if (in_data_i.cmd) begin
      strafe_d = '0;
      move_d   = '0;
      turn_d   = '0;
      integ_d  = '0;
      pitch_d  = drt_pkg::PitchRest;
    end else if (in_data_i.link_up) begin
      strafe_d = strafe_step;
      move_d   = move_step;
      turn_d   = turn_step;
      integ_d  = integ_step;
      pitch_d  = pitch_step;
    end
    pitch_prod = 25'(pitch_d) * 25'(drt_pkg::PitchScale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_accel     <= drt_pkg::MoveAccelReset;
      cfg_q.move_brake     <= drt_pkg::MoveBrakeReset;
      cfg_q.turn_accel     <= drt_pkg::TurnAccelReset;
      cfg_q.turn_dead_zone <= drt_pkg::TurnDeadZoneReset;
      cfg_q.turn_limit     <= drt_pkg::TurnLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        drt_pkg::CfgMoveAccel:    cfg_q.move_accel     <= cfg_data_i[6:0];
        drt_pkg::CfgMoveBrake:    cfg_q.move_brake     <= cfg_data_i[6:0];
        drt_pkg::CfgTurnAccel:    cfg_q.turn_accel     <= cfg_data_i[6:0];
        drt_pkg::CfgTurnDeadZone: cfg_q.turn_dead_zone <= cfg_data_i[6:0];
        drt_pkg::CfgTurnLimit:    cfg_q.turn_limit     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strafe_q    <= '0;
      move_q      <= '0;
      turn_q      <= '0;
      integ_q     <= '0;
      pitch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        strafe_q <= strafe_d;
        move_q   <= move_d;
        turn_q   <= turn_d;
        integ_q  <= integ_d;
        pitch_q  <= pitch_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q.strafe_drive   <= strafe_d;
      out_q.move_drive     <= move_d;
      out_q.turn_drive     <= turn_d;
      out_q.pitch_position <= pitch_d;
      out_q.pitch_byte     <= pitch_prod[23:16];
    end
  end

endmodule

// ----- src/drt_ramp.sv -----
// One drive axis: forms the key-adjusted target and steps the value toward it.
// Depends on drt_pkg for the drive limit constant.
module drt_ramp (
  input  logic signed [7:0] cur_i,
  input  logic signed [7:0] stick_i,
  input  logic              key_neg_i,
  input  logic              key_pos_i,
  input  logic [6:0]        accel_i,
  input  logic [6:0]        brake_i,
  output logic signed [7:0] next_o
);

  logic signed [9:0] tgt_raw;
  logic signed [9:0] tgt;
  logic signed [9:0] cur;
  logic signed [9:0] acc;
  logic signed [9:0] brk;
  logic signed [9:0] v;
  logic signed [9:0] res;

  always_comb begin
    tgt_raw = 10'(stick_i);
    if (key_neg_i) tgt_raw = tgt_raw - drt_pkg::DriveMax;
    if (key_pos_i) tgt_raw = tgt_raw + drt_pkg::DriveMax;
    if (tgt_raw < -drt_pkg::DriveMax) begin
      tgt = -drt_pkg::DriveMax;
    end else if (tgt_raw > drt_pkg::DriveMax) begin
      tgt = drt_pkg::DriveMax;
    end else begin
      tgt = tgt_raw;
    end

    cur = 10'(cur_i);
    acc = $signed({3'b000, accel_i});
    brk = $signed({3'b000, brake_i});
    if (!cur[9]) begin
      if (cur > tgt) begin
        v   = cur - brk;
        res = (v > tgt) ? v : tgt;
      end else begin
        v   = cur + acc;
        res = (v < tgt) ? v : tgt;
      end
    end else begin
      if (cur < tgt) begin
        v   = cur + brk;
        res = (v < tgt) ? v : tgt;
      end else begin
        v   = cur - acc;
        res = (v > tgt) ? v : tgt;
      end
    end
    next_o = res[7:0];
  end

endmodule

// ----- src/drt_turn.sv -----
// Turn integrator update and the capped, dead-zoned turn drive ramp.
// Depends on drt_pkg for the configuration struct and constants.
module drt_turn (
  input  logic signed [12:0] integ_i,
  input  logic signed [7:0]  turn_i,
  input  logic signed [15:0] delta_i,
  input  drt_pkg::cfg_t      cfg_i,
  output logic signed [12:0] integ_o,
  output logic signed [7:0]  turn_o
);

  logic signed [14:0] diff;
  logic signed [14:0] diff_adj;
  logic signed [13:0] half;
  logic signed [17:0] sum;
  logic signed [17:0] lim;
  logic signed [12:0] integ;
  logic signed [12:0] dz;
  logic [11:0]        mag;
  logic [23:0]        prod;
  logic signed [11:0] quot;
  logic signed [11:0] tv;
  logic signed [11:0] acc;
  logic signed [11:0] stepped;
  logic signed [11:0] cap;
  logic signed [11:0] res;

  always_comb begin
    // Halving by a shift rounds down, so a negative value is raised by one first to truncate toward zero.
    diff     = $signed({integ_i[12], integ_i, 1'b0}) - 15'(turn_i);
    diff_adj = diff + $signed({14'd0, diff[14]});
    half     = diff_adj[14:1];
    sum      = 18'(half) + 18'(delta_i);
    lim      = $signed({6'd0, cfg_i.turn_limit});
    if (sum > lim) begin
      integ = lim[12:0];
    end else if (sum < -lim) begin
      integ = 13'(-lim);
    end else begin
      integ = sum[12:0];
    end
    integ_o = integ;

    dz   = $signed({6'd0, cfg_i.turn_dead_zone});
    mag  = integ[12] ? 12'(-integ) : integ[11:0];
    prod = 24'(mag) * 24'(drt_pkg::Div6Recip);
    quot = $signed({2'b00, prod[23:14]});
    tv   = 12'(turn_i);
    acc  = $signed({5'd0, cfg_i.turn_accel});

    if (integ > dz) begin
      stepped = (tv < 12'(drt_pkg::DriveMax) - acc) ? tv + acc : 12'(drt_pkg::DriveMax);
      cap     = quot + 12'(dz);
      res     = (stepped > cap) ? cap : stepped;
    end else if (integ < -dz) begin
      stepped = (tv > acc - 12'(drt_pkg::DriveMax)) ? tv - acc : -12'(drt_pkg::DriveMax);
      cap     = -quot - 12'(dz);
      res     = (stepped < cap) ? cap : stepped;
    end else begin
      stepped = '0;
      cap     = '0;
      res     = '0;
    end
    turn_o = res[7:0];
  end

endmodule

// ----- src/drt_checker.sv -----
// Port-level assertions for the drive ramp and turn integrator, bound to its top level.
// Depends on drt_pkg for the item structs and the rest pitch constant.
module drt_assertions (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input drt_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input drt_pkg::out_item_t out_data_o
);

  a_ready_only_stalls_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("Input stalled while the result register could take an item.");

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("Accepted item produced no result.");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.cmd) |=>
      (out_data_o.strafe_drive == 8'sd0 && out_data_o.move_drive == 8'sd0 &&
       out_data_o.turn_drive == 8'sd0 && out_data_o.pitch_position == drt_pkg::PitchRest))
    else $error("Stop item did not clear motion and rest the pitch.");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pitch_position <= 10'd850 &&
                     out_data_o.strafe_drive != -8'sd128 &&
                     out_data_o.move_drive != -8'sd128 &&
                     out_data_o.turn_drive != -8'sd128))
    else $error("Result outside its range.");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("Stalled result changed.");

endmodule

bind drive_ramp_turn_integrator_top drt_assertions u_drt_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- dv/drt_checker.sv -----
// Checker for the drive ramp and turn integrator: watches the item, result and register
// channels, predicts every result and compares it field by field with what the block shows.
// Depends on drt_pkg for the item structs, the register struct and the register indexes.
module drt_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  drt_pkg::in_item_t                in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  drt_pkg::out_item_t               out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [drt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [drt_pkg::CfgDataWidth-1:0] cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int DriveLimit  = 127;
  localparam int PitchTop    = 850;
  localparam int PitchHome   = 550;
  localparam int TurnDivisor = 6;

  drt_pkg::cfg_t      reg_set;
  drt_pkg::out_item_t drive_results_q[$];
  drt_pkg::out_item_t predicted;
  drt_pkg::out_item_t oldest;
  int strafe_val, move_val, turn_val, turn_acc, pitch_val;
  int fault_total = 0;

  assign fail_count_o = fault_total;

  task automatic report_fault(string text);
    $display("%0t checker: %s", $time, text);
    fault_total++;
  endtask

  task automatic check_field(string name, logic signed [15:0] got, logic signed [15:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s is %0d, predicted %0d", name, got, want));
    end
  endtask

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int ramp_toward(int cur, int tgt);
    int up, down, v;
    up = reg_set.move_accel;
    down = reg_set.move_brake;
    if (cur >= 0) begin
      if (cur > tgt) begin
        v = cur - down;
        return (v > tgt) ? v : tgt;
      end
      v = cur + up;
      return (v < tgt) ? v : tgt;
    end
    if (cur < tgt) begin
      v = cur + down;
      return (v < tgt) ? v : tgt;
    end
    v = cur - up;
    return (v > tgt) ? v : tgt;
  endfunction

  task automatic advance_drive(input drt_pkg::in_item_t it, output drt_pkg::out_item_t res);
    int tx, ty, lim, dz, acc, cap;
    if (it.cmd) begin
      strafe_val = 0;
      move_val = 0;
      turn_val = 0;
      turn_acc = 0;
      pitch_val = PitchHome;
    end else if (it.link_up) begin
      tx = $signed(it.stick_x);
      ty = $signed(it.stick_y);
      if (it.keys[0]) tx -= DriveLimit;
      if (it.keys[1]) tx += DriveLimit;
      if (it.keys[2]) ty -= DriveLimit;
      if (it.keys[3]) ty += DriveLimit;
      strafe_val = ramp_toward(strafe_val, clamp_int(tx, -DriveLimit, DriveLimit));
      move_val = ramp_toward(move_val, clamp_int(ty, -DriveLimit, DriveLimit));

      lim = reg_set.turn_limit;
      dz = reg_set.turn_dead_zone;
      acc = reg_set.turn_accel;
      turn_acc = (2 * turn_acc - turn_val) / 2;
      turn_acc = clamp_int(turn_acc + $signed(it.turn_delta), -lim, lim);
      if (turn_acc > dz) begin
        turn_val = (turn_val < DriveLimit - acc) ? turn_val + acc : DriveLimit;
        cap = turn_acc / TurnDivisor + dz;
        if (turn_val > cap) turn_val = cap;
      end else if (turn_acc < -dz) begin
        turn_val = (turn_val > -(DriveLimit - acc)) ? turn_val - acc : -DriveLimit;
        cap = turn_acc / TurnDivisor - dz;
        if (turn_val < cap) turn_val = cap;
      end else begin
        turn_val = 0;
      end

      pitch_val = clamp_int(pitch_val + $signed(it.pitch_delta), 0, PitchTop);
    end
    res.strafe_drive = strafe_val[7:0];
    res.move_drive = move_val[7:0];
    res.turn_drive = turn_val[7:0];
    res.pitch_position = pitch_val[9:0];
    res.pitch_byte = 8'((pitch_val * 3) / 10);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_set.move_accel = drt_pkg::MoveAccelReset;
      reg_set.move_brake = drt_pkg::MoveBrakeReset;
      reg_set.turn_accel = drt_pkg::TurnAccelReset;
      reg_set.turn_dead_zone = drt_pkg::TurnDeadZoneReset;
      reg_set.turn_limit = drt_pkg::TurnLimitReset;
      strafe_val = 0;
      move_val = 0;
      turn_val = 0;
      turn_acc = 0;
      pitch_val = 0;
      drive_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          drt_pkg::CfgMoveAccel:    reg_set.move_accel = cfg_data_i[6:0];
          drt_pkg::CfgMoveBrake:    reg_set.move_brake = cfg_data_i[6:0];
          drt_pkg::CfgTurnAccel:    reg_set.turn_accel = cfg_data_i[6:0];
          drt_pkg::CfgTurnDeadZone: reg_set.turn_dead_zone = cfg_data_i[6:0];
          drt_pkg::CfgTurnLimit:    reg_set.turn_limit = cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_results_q.size() == 0) begin
          report_fault("result shown with no item outstanding");
        end else begin
          oldest = drive_results_q.pop_front();
          check_field("strafe_drive", out_data_i.strafe_drive, oldest.strafe_drive);
          check_field("move_drive", out_data_i.move_drive, oldest.move_drive);
          check_field("turn_drive", out_data_i.turn_drive, oldest.turn_drive);
          check_field("pitch_position", out_data_i.pitch_position, oldest.pitch_position);
          check_field("pitch_byte", out_data_i.pitch_byte, oldest.pitch_byte);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_drive(in_data_i, predicted);
        drive_results_q.push_back(predicted);
      end
      pending_o <= drive_results_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the drive ramp and turn integrator testbench: clock, reset, stimulus and verdict.
// Depends on drt_pkg, drive_ramp_turn_integrator_top and the drt_checker module.
module tb_top;

  localparam int HoldOffCycles = 300;
  localparam int StallLimit    = 3000;
  localparam int PhaseCount    = 6;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  drt_pkg::in_item_t                in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  drt_pkg::out_item_t               out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [drt_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
  logic [drt_pkg::CfgDataWidth-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int idle_cycles = 0;
  drt_pkg::cfg_t phase_cfg[PhaseCount];

  drive_ramp_turn_integrator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  drt_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver holds off for a long stretch whenever the stimulus asks for it.
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        repeat (HoldOffCycles) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic drt_pkg::in_item_t drive_tick(logic signed [7:0] sx, logic signed [7:0] sy,
                                                   logic [3:0] k, logic signed [15:0] td,
                                                   logic signed [15:0] pd);
    drt_pkg::in_item_t it;
    it.cmd = 1'b0;
    it.link_up = 1'b1;
    it.stick_x = sx;
    it.stick_y = sy;
    it.keys = k;
    it.turn_delta = td;
    it.pitch_delta = pd;
    return it;
  endfunction

  function automatic logic signed [15:0] rand_delta(int span);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic signed [7:0] pick_stick();
    case ($urandom_range(5))
      0: return 8'sh7f;
      1: return 8'sh80;
      2: return 8'sh00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic drt_pkg::cfg_t random_setting(int max_limit);
    drt_pkg::cfg_t s;
    s.move_accel = 7'($urandom_range(20));
    s.move_brake = 7'($urandom_range(40));
    s.turn_accel = 7'($urandom_range(30));
    s.turn_dead_zone = 7'($urandom_range(15));
    s.turn_limit = 12'($urandom_range(max_limit));
    return s;
  endfunction

  task automatic send_item(drt_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [drt_pkg::CfgIdxWidth-1:0] idx,
                           logic [drt_pkg::CfgDataWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Bits above a short register are filled with noise; the block must drop them.
  task automatic write_setting(drt_pkg::cfg_t s);
    write_reg(drt_pkg::CfgMoveAccel, {5'($urandom), s.move_accel});
    write_reg(drt_pkg::CfgMoveBrake, {5'($urandom), s.move_brake});
    write_reg(drt_pkg::CfgTurnAccel, {5'($urandom), s.turn_accel});
    write_reg(drt_pkg::CfgTurnDeadZone, {5'($urandom), s.turn_dead_zone});
    write_reg(drt_pkg::CfgTurnLimit, s.turn_limit);
  endtask

  // Mostly held stick positions with small mouse motion, so that ramps reach their targets
  // and the turn integrator settles, broken up by stop items, link drops and raw noise.
  task automatic run_phase(int count);
    int sent, run_len, span;
    logic signed [7:0] sx, sy;
    logic [3:0] k;
    logic [63:0] raw;
    drt_pkg::in_item_t it;
    sent = 0;
    while (sent < count) begin
      run_len = $urandom_range(24, 1);
      sx = pick_stick();
      sy = pick_stick();
      k = ($urandom_range(2) == 0) ? 4'($urandom) : 4'b0000;
      case ($urandom_range(2))
        0: span = 8;
        1: span = 60;
        default: span = 400;
      endcase
      repeat (run_len) begin
        it = drive_tick(sx, sy, k, rand_delta(span), rand_delta(40));
        case ($urandom_range(19))
          0: it.cmd = 1'b1;
          1: it.link_up = 1'b0;
          2: begin
            raw = {$urandom, $urandom};
            it = raw[$bits(drt_pkg::in_item_t)-1:0];
          end
          default: ;
        endcase
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    drt_pkg::in_item_t it;
    phase_cfg[0] = random_setting(1500);
    phase_cfg[1] = '{move_accel: 7'd0, move_brake: 7'd0, turn_accel: 7'd0,
                     turn_dead_zone: 7'd0, turn_limit: 12'd0};
    phase_cfg[2] = '{move_accel: 7'd127, move_brake: 7'd127, turn_accel: 7'd127,
                     turn_dead_zone: 7'd127, turn_limit: 12'd4095};
    phase_cfg[3] = random_setting(4095);
    phase_cfg[4] = '{move_accel: 7'd1, move_brake: 7'd127, turn_accel: 7'd127,
                     turn_dead_zone: 7'd0, turn_limit: 12'd4095};
    phase_cfg[5] = random_setting(200);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(drive_tick(8'sh00, 8'sh00, 4'b0000, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh7f, 8'sh80, 4'b0000, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh80, 8'sh7f, 4'b0000, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0001, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0010, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0100, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b1000, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh7f, 8'sh80, 4'b1111, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh80, 8'sh7f, 4'b0011, 16'sh0000, 16'sh0000));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0000, 16'sh0002, 16'sh0005));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0000, 16'sh7fff, 16'sh7fff));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0000, 16'sh7fff, 16'sh0001));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0000, 16'sh8000, 16'sh8000));
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0000, 16'shfffe, 16'sh0000));
    it = drive_tick(8'sh64, 8'sh9c, 4'b1111, 16'sh01f4, 16'sh01f4);
    it.link_up = 1'b0;
    send_item(it);
    it = drive_tick(8'sh7f, 8'sh7f, 4'b0000, 16'sh0100, 16'sh0100);
    it.cmd = 1'b1;
    send_item(it);
    it = drive_tick(8'sh80, 8'sh80, 4'b1111, 16'sh8000, 16'sh7fff);
    it.cmd = 1'b1;
    it.link_up = 1'b0;
    send_item(it);
    send_item(drive_tick(8'sh00, 8'sh00, 4'b0000, 16'sh0028, 16'sh012c));
    send_item(drive_tick(8'sh80, 8'sh80, 4'b1100, 16'shffd8, 16'shffff));
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 8;
          recv_stall_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_setting(phase_cfg[ph]);
      if (ph == 4) hold_req++;
      run_phase(130);
      drain();
      run_phase(130);
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
